// ===== rtl/antsel_pkg.sv =====
`timescale 1ns / 1ps

package antsel_pkg;

    // Widths fixed by the item fields.
    localparam int IDX_W      = 3;
    localparam int MASK_W     = 6;
    localparam int SAVE_W     = 8;
    localparam int NUM_ANT    = 6;
    localparam logic [1:0] SAVE_MARK = 2'b11;

    // One user event item.
    typedef struct packed {
        logic init_request;
        logic long_press;
        logic click;
        logic step_left;
        logic step_right;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0]  selected_antenna;
        logic              none_enabled;
        logic              drive_update;
        logic              edit_mode;
        logic              alt_view;
        logic [MASK_W-1:0] enable_bits;
        logic              save_strobe;
        logic [SAVE_W-1:0] save_value;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } seq_state_t;

    // An antenna counts as enabled only if it exists and its mask bit is set.
    function automatic logic ant_enabled(input logic [MASK_W-1:0] mask,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [IDX_W:0] num_ant);
        logic res;
        res = ({1'b0, idx} < num_ant) && mask[idx];
        return res;
    endfunction

endpackage

// ===== rtl/antsel_step.sv =====
`timescale 1ns / 1ps

module antsel_step #(
    parameter int NUM_ANTENNAS = antsel_pkg::NUM_ANT
) (
    input  logic [antsel_pkg::IDX_W-1:0]  idx,
    input  logic                          up,
    input  logic [antsel_pkg::MASK_W-1:0] mask,
    output logic [antsel_pkg::IDX_W-1:0]  next_idx,
    output logic                          next_enabled
);
    import antsel_pkg::*;

    localparam logic [IDX_W:0]   NUM_W = (IDX_W+1)'(NUM_ANTENNAS);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_ANTENNAS - 1);

    logic [IDX_W:0] idx_inc;

    // One wraparound move and the enable test of the antenna it lands on.
    always_comb
    begin
        idx_inc = {1'b0, idx} + (IDX_W+1)'(1);
        if (up)
        begin
            next_idx = (idx_inc >= NUM_W) ? '0 : idx_inc[IDX_W-1:0];
        end
        else
        begin
            next_idx = (idx == '0 || {1'b0, idx} >= NUM_W) ? LAST : idx - IDX_W'(1);
        end
        next_enabled = ant_enabled(mask, next_idx, NUM_W);
    end

endmodule

// ===== rtl/antsel_core.sv =====
`timescale 1ns / 1ps

module antsel_core #(
    parameter int NUM_ANTENNAS = antsel_pkg::NUM_ANT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [antsel_pkg::MASK_W-1:0] stored_mask,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  antsel_pkg::in_item_t          in_data,
    output logic                          res_valid,
    input  logic                          res_taken,
    output antsel_pkg::out_item_t         res_data
);
    import antsel_pkg::*;

    localparam logic [IDX_W:0]   NUM_W = (IDX_W+1)'(NUM_ANTENNAS);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_ANTENNAS - 1);

    seq_state_t        state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              none_reg, none_next;
    logic              alt_reg, alt_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              scan_up_reg, scan_up_next;
    logic [IDX_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]  old_idx_reg, old_idx_next;
    logic              old_none_reg, old_none_next;
    logic              force_drive_reg, force_drive_next;
    logic              cmp_drive_reg, cmp_drive_next;
    logic              save_reg, save_next;

    logic [IDX_W-1:0]  step_idx;
    logic              step_up;
    logic [IDX_W-1:0]  step_next_idx;
    logic              step_next_en;
    logic              changed;

    // The shared step unit serves both the scan and the plain edit-mode moves.
    assign step_idx = (state_reg == ST_SCAN) ? scan_idx_reg : idx_reg;
    assign step_up  = (state_reg == ST_SCAN) ? scan_up_reg : !in_data.step_left;

    antsel_step #(
        .NUM_ANTENNAS(NUM_ANTENNAS)
    ) u_step (
        .idx         (step_idx),
        .up          (step_up),
        .mask        (mask_reg),
        .next_idx    (step_next_idx),
        .next_enabled(step_next_en)
    );

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= 1'b0;
            idx_reg         <= '0;
            none_reg        <= 1'b0;
            alt_reg         <= 1'b0;
            mask_reg        <= '0;
            scan_idx_reg    <= '0;
            scan_up_reg     <= 1'b0;
            scan_cnt_reg    <= '0;
            old_idx_reg     <= '0;
            old_none_reg    <= 1'b0;
            force_drive_reg <= 1'b0;
            cmp_drive_reg   <= 1'b0;
            save_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            idx_reg         <= idx_next;
            none_reg        <= none_next;
            alt_reg         <= alt_next;
            mask_reg        <= mask_next;
            scan_idx_reg    <= scan_idx_next;
            scan_up_reg     <= scan_up_next;
            scan_cnt_reg    <= scan_cnt_next;
            old_idx_reg     <= old_idx_next;
            old_none_reg    <= old_none_next;
            force_drive_reg <= force_drive_next;
            cmp_drive_reg   <= cmp_drive_next;
            save_reg        <= save_next;
        end
    end

    // Event decode, scan sequencing and result handoff.
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        idx_next         = idx_reg;
        none_next        = none_reg;
        alt_next         = alt_reg;
        mask_next        = mask_reg;
        scan_idx_next    = scan_idx_reg;
        scan_up_next     = scan_up_reg;
        scan_cnt_next    = scan_cnt_reg;
        old_idx_next     = old_idx_reg;
        old_none_next    = old_none_reg;
        force_drive_next = force_drive_reg;
        cmp_drive_next   = cmp_drive_reg;
        save_next        = save_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    old_idx_next     = idx_reg;
                    old_none_next    = none_reg;
                    force_drive_next = 1'b0;
                    cmp_drive_next   = 1'b0;
                    save_next        = 1'b0;
                    state_next       = ST_EMIT;
                    scan_idx_next    = none_reg ? '0 : idx_reg;
                    scan_cnt_next    = '0;
                    scan_up_next     = 1'b1;

                    if (in_data.init_request)
                    begin
                        // Load the saved mask and keep the selection if still valid.
                        mask_next        = stored_mask;
                        force_drive_next = 1'b1;
                        if (none_reg || !ant_enabled(stored_mask, idx_reg, NUM_W))
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (!mode_reg)
                    begin
                        cmp_drive_next = 1'b1;
                        if (in_data.long_press)
                        begin
                            mode_next = 1'b1;
                            if (none_reg)
                            begin
                                idx_next  = LAST;
                                none_next = 1'b0;
                            end
                        end
                        else if (in_data.click)
                        begin
                            alt_next = !alt_reg;
                        end
                        else if (in_data.step_left || in_data.step_right)
                        begin
                            scan_up_next = !in_data.step_left;
                            state_next   = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (in_data.long_press)
                        begin
                            // Leave edit mode, request a save and reselect.
                            mode_next        = 1'b0;
                            save_next        = 1'b1;
                            force_drive_next = 1'b1;
                            if (none_reg || !ant_enabled(mask_reg, idx_reg, NUM_W))
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        else if (in_data.click)
                        begin
                            if (!none_reg && ({1'b0, idx_reg} < NUM_W))
                            begin
                                mask_next = mask_reg;
                                mask_next[idx_reg] = !mask_reg[idx_reg];
                            end
                        end
                        else if (in_data.step_left || in_data.step_right)
                        begin
                            if (none_reg)
                            begin
                                idx_next  = in_data.step_left ? LAST : '0;
                                none_next = 1'b0;
                            end
                            else
                            begin
                                idx_next = step_next_idx;
                            end
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // One candidate antenna per cycle.
                if (step_next_en)
                begin
                    idx_next   = step_next_idx;
                    none_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (scan_cnt_reg == LAST)
                begin
                    idx_next   = '0;
                    none_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_idx_next = step_next_idx;
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end

            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_taken)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields come straight from the updated state.
    assign changed = (idx_reg != old_idx_reg) || (none_reg != old_none_reg);

    always_comb
    begin
        res_data.selected_antenna = none_reg ? '0 : idx_reg;
        res_data.none_enabled     = none_reg;
        res_data.drive_update     = force_drive_reg || (cmp_drive_reg && changed);
        res_data.edit_mode        = mode_reg;
        res_data.alt_view         = alt_reg;
        res_data.enable_bits      = mask_reg;
        res_data.save_strobe      = save_reg;
        res_data.save_value       = save_reg ? {SAVE_MARK, mask_reg} : '0;
    end

endmodule

// ===== rtl/antenna_switch_selector.sv =====
`timescale 1ns / 1ps

// Channel   Signals                         Direction  Content
// config    cfg_we, cfg_wdata               in         saved enable mask, 6 bits
// events    in_valid, in_ready, in_data     in         one decoded user event
// results   out_valid, out_ready, out_data  out        selection, mode, mask, save
//
// An item goes straight from idle to the emit state when no scan is needed, and
// through the scan state when the selection must search for an enabled antenna;
// the search tests one antenna per cycle through the shared step unit.
// Reset clears all state, sets the saved mask to all ones and empties the output.
// A stalled output register holds the next result in the core until it drains.

module antenna_switch_selector #(
    parameter int NUM_ANTENNAS = antsel_pkg::NUM_ANT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [antsel_pkg::MASK_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  antsel_pkg::in_item_t          in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output antsel_pkg::out_item_t         out_data
);
    import antsel_pkg::*;

    logic [MASK_W-1:0] stored_mask_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg;
    logic              res_valid;
    logic              res_taken;
    out_item_t         res_data;

    // Saved enable mask register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_mask_reg <= {MASK_W{1'b1}};
        end
        else if (cfg_we)
        begin
            stored_mask_reg <= cfg_wdata;
        end
    end

    antsel_core #(
        .NUM_ANTENNAS(NUM_ANTENNAS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .stored_mask(stored_mask_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .res_valid  (res_valid),
        .res_taken  (res_taken),
        .res_data   (res_data)
    );

    // Output register takes a new result whenever it is empty or draining.
    assign res_taken = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import antsel_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          SETTLE       = NUM_ANT + 4;
    localparam logic [7:0]  SAVE_FLAGS   = 8'hC0;
    localparam int          PRINT_CAP    = 30;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [MASK_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;

    // Shadow copy of the selector state and its saved mask.
    bit                edit_on;
    logic [IDX_W-1:0]  sel_idx;
    bit                sel_none;
    bit                alt_on;
    logic [MASK_W-1:0] live_mask;
    logic [MASK_W-1:0] saved_mask;

    out_item_t pending_results[$];

    int  error_count     = 0;
    int  results_seen    = 0;
    int  events_sent     = 0;
    int  saves_seen      = 0;
    int  config_writes   = 0;
    int  cycle_count     = 0;
    int  hold_off_cycles = 0;
    bit  gaps_on         = 1'b1;

    antenna_switch_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Index arithmetic with wraparound over the fitted antennas.
    function automatic logic [IDX_W-1:0] wrap_next(logic [IDX_W-1:0] i, bit up);
        int k;
        k = i;
        if (up)
            k = (k + 1 >= NUM_ANT) ? 0 : k + 1;
        else
            k = (k == 0 || k >= NUM_ANT) ? NUM_ANT - 1 : k - 1;
        return k[IDX_W-1:0];
    endfunction

    function automatic bit ant_on(logic [IDX_W-1:0] i);
        return (int'(i) < NUM_ANT) && live_mask[i];
    endfunction

    // Walk from the current antenna to the next enabled one, or to none.
    function automatic void seek_enabled(bit up);
        logic [IDX_W-1:0] i;
        bit found;
        i = sel_none ? '0 : sel_idx;
        found = 1'b0;
        for (int n = 0; n < NUM_ANT && !found; n++)
        begin
            i = wrap_next(i, up);
            if (ant_on(i))
                found = 1'b1;
        end
        sel_idx  = found ? i : '0;
        sel_none = !found;
    endfunction

    function automatic void reselect();
        if (sel_none || !ant_on(sel_idx))
            seek_enabled(1'b1);
    endfunction

    // Apply one event to the shadow state and return the result it must produce.
    function automatic out_item_t apply_event(in_item_t ev);
        out_item_t        r;
        logic [IDX_W-1:0] old_idx;
        bit               old_none;
        bit               up;
        r        = '0;
        old_idx  = sel_idx;
        old_none = sel_none;
        if (ev.init_request)
        begin
            live_mask = saved_mask;
            reselect();
            r.drive_update = 1'b1;
        end
        else if (!edit_on)
        begin
            if (ev.long_press)
            begin
                edit_on = 1'b1;
                if (sel_none)
                begin
                    sel_idx  = IDX_W'(NUM_ANT - 1);
                    sel_none = 1'b0;
                end
            end
            else if (ev.click)
                alt_on = !alt_on;
            else if (ev.step_left)
                seek_enabled(1'b0);
            else if (ev.step_right)
                seek_enabled(1'b1);
            r.drive_update = (sel_idx != old_idx) || (sel_none != old_none);
        end
        else
        begin
            if (ev.long_press)
            begin
                edit_on        = 1'b0;
                r.save_strobe  = 1'b1;
                r.save_value   = SAVE_FLAGS | 8'(live_mask);
                reselect();
                r.drive_update = 1'b1;
            end
            else if (ev.click)
            begin
                if (!sel_none && int'(sel_idx) < NUM_ANT)
                    live_mask[sel_idx] = ~live_mask[sel_idx];
            end
            else if (ev.step_left || ev.step_right)
            begin
                up = !ev.step_left;
                if (sel_none)
                begin
                    sel_idx  = up ? '0 : IDX_W'(NUM_ANT - 1);
                    sel_none = 1'b0;
                end
                else
                    sel_idx = wrap_next(sel_idx, up);
            end
        end
        r.selected_antenna = sel_none ? '0 : sel_idx;
        r.none_enabled     = sel_none;
        r.edit_mode        = edit_on;
        r.alt_view         = alt_on;
        r.enable_bits      = live_mask;
        return r;
    endfunction

    function automatic in_item_t mk_event(bit init, bit long_p, bit clk_ev, bit left, bit right);
        in_item_t ev;
        ev = '{init, long_p, clk_ev, left, right};
        return ev;
    endfunction

    // Mostly single well-formed events, some with losing lower-priority flags, some noise.
    function automatic in_item_t random_event();
        logic [4:0] flags;
        int         pick;
        pick  = $urandom_range(0, 99);
        flags = '0;
        if (pick < 6)
            flags = 5'($urandom_range(0, 31));
        else
        begin
            if (pick < 11)
                flags = 5'b10000;
            else if (pick < 24)
                flags = 5'b01000;
            else if (pick < 42)
                flags = 5'b00100;
            else if (pick < 71)
                flags = 5'b00010;
            else
                flags = 5'b00001;
            if ($urandom_range(0, 4) == 0)
                flags = flags | (5'($urandom_range(0, 31)) & (flags - 5'd1));
        end
        return in_item_t'(flags);
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Offer one event after a random gap and record its expected result on transfer.
    task automatic send_event(in_item_t ev);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_event(ev));
        if (ev != '0)
            events_sent++;
    endtask

    task automatic send_random(int count);
        in_item_t ev;
        int       sent;
        sent = 0;
        while (sent < count)
        begin
            ev = random_event();
            send_event(ev);
            if (ev != '0)
                sent++;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_saved_mask(logic [MASK_W-1:0] m);
        wait_for_results();
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        saved_mask = m;
        config_writes++;
    endtask

    // Hand-picked walk through both modes, the empty selection and flag priority.
    task automatic test_directed_events();
        send_event(mk_event(0, 0, 0, 0, 0));
        send_event(mk_event(0, 0, 0, 0, 1));
        send_event(mk_event(0, 0, 0, 1, 0));
        send_event(mk_event(0, 0, 1, 0, 0));
        send_event(mk_event(0, 1, 0, 0, 0));
        send_event(mk_event(0, 1, 0, 0, 0));
        send_event(mk_event(0, 1, 0, 0, 0));
        write_saved_mask('0);
        send_event(mk_event(1, 0, 0, 0, 0));
        send_event(mk_event(0, 0, 1, 0, 0));
        send_event(mk_event(0, 0, 0, 0, 1));
        send_event(mk_event(1, 0, 0, 0, 0));
        send_event(mk_event(0, 0, 0, 1, 0));
        send_event(mk_event(0, 0, 1, 0, 0));
        send_event(mk_event(0, 0, 0, 1, 0));
        send_event(mk_event(0, 0, 1, 0, 0));
        send_event(mk_event(0, 0, 0, 0, 1));
        send_event(mk_event(0, 0, 0, 0, 1));
        send_event(mk_event(0, 0, 1, 0, 0));
        send_event(mk_event(0, 1, 0, 0, 0));
        send_event(mk_event(0, 0, 0, 0, 1));
        send_event(mk_event(0, 0, 0, 1, 0));
        write_saved_mask('1);
        send_event(mk_event(1, 1, 1, 1, 1));
        send_event(mk_event(0, 1, 1, 1, 1));
        send_event(mk_event(0, 0, 1, 1, 1));
        send_event(mk_event(0, 0, 0, 1, 1));
        send_event(mk_event(0, 1, 0, 0, 0));
    endtask

    // Sessions under different saved masks, each opened with an init.
    task automatic test_random_sessions();
        logic [MASK_W-1:0] masks[8];
        masks[0] = '0;
        masks[1] = '1;
        masks[2] = 6'b000001;
        masks[3] = 6'b100000;
        for (int k = 4; k < 8; k++)
            masks[k] = MASK_W'($urandom_range(0, 63));
        foreach (masks[k])
        begin
            write_saved_mask(masks[k]);
            send_event(mk_event(1, 0, 0, 0, 0));
            send_random(55);
        end
    endtask

    // The receiver holds off for a long stretch while events keep coming.
    task automatic test_output_stall();
        wait_for_results();
        gaps_on         = 1'b0;
        hold_off_cycles = 250;
        send_random(40);
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        write_saved_mask(MASK_W'($urandom_range(0, 63)));
        gaps_on = 1'b0;
        send_event(mk_event(1, 0, 0, 0, 0));
        send_random(40);
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    // Result side: random stalls after each transfer, plus the long hold-off.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                stall_left = gaps_on ? $urandom_range(0, 3) : 0;
                out_ready <= (stall_left == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= (stall_left == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", out_data));
            else
            begin
                want = pending_results.pop_front();
                if (want.save_strobe)
                    saves_seen++;
                check_field("selected_antenna", out_data.selected_antenna,
                            want.selected_antenna);
                check_field("none_enabled", out_data.none_enabled, want.none_enabled);
                check_field("drive_update", out_data.drive_update, want.drive_update);
                check_field("edit_mode", out_data.edit_mode, want.edit_mode);
                check_field("alt_view", out_data.alt_view, want.alt_view);
                check_field("enable_bits", out_data.enable_bits, want.enable_bits);
                check_field("save_strobe", out_data.save_strobe, want.save_strobe);
                check_field("save_value", out_data.save_value, want.save_value);
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        edit_on    = 1'b0;
        sel_idx    = '0;
        sel_none   = 1'b0;
        alt_on     = 1'b0;
        live_mask  = '0;
        saved_mask = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_random_sessions();
        test_output_stall();
        test_back_to_back();
        wait_for_results();
        $display("covered %0d events, %0d results checked, %0d saves, %0d mask writes",
                 events_sent, results_seen, saves_seen, config_writes);
        $display("with random gaps on both sides, back-to-back runs and a long output stall");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
